FILE: src/sbda_pkg.sv
// shared constants and control types for the signed binary to decimal ascii converter
`default_nettype none

package sbda_pkg;

  localparam int DATA_WIDTH = 32;
  // decimal digits needed for a DATA_WIDTH-bit magnitude, 1233/4096 ~ log10(2)
  localparam int NUM_DIGITS = ((DATA_WIDTH * 1233) >> 12) + 1;
  localparam int BCD_W      = NUM_DIGITS * 4;
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int CHAR_W     = 7;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'd57;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

  typedef struct packed {
    logic load;
    logic shift;
    logic locate;
    logic emit_sign;
    logic emit_digit;
  } sbda_cmd_t;

  typedef struct packed {
    logic neg;
    logic idx_zero;
  } sbda_sts_t;

endpackage

`default_nettype wire

FILE: src/sbda_dp.sv
// datapath: double-dabble conversion register, digit locate and character output
`default_nettype none

module sbda_dp
  import sbda_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire sbda_cmd_t                    cmd_i,
  input  wire logic signed [DATA_WIDTH-1:0] value_i,
  output sbda_sts_t                         sts_o,
  output logic [CHAR_W-1:0]                 character_o,
  output logic                              last_o,
  output logic                              out_valid_o
);

  logic [DATA_WIDTH-1:0] mag_q, mag_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic [BCD_W-1:0]      bcd_adj;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [IDX_W-1:0]      lead;
  logic                  neg_q, neg_d;
  logic [CHAR_W-1:0]     char_q, char_d;
  logic                  last_q, last_d;
  logic                  valid_q, valid_d;
  logic [DATA_WIDTH-1:0] value_u;

  assign value_u = $unsigned(value_i);

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  // highest nonzero digit, digit zero when the value is zero
  always_comb begin
    lead = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] != 4'd0) begin
        lead = IDX_W'(i);
      end
    end
  end

  always_comb begin
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    idx_d   = idx_q;
    neg_d   = neg_q;
    char_d  = char_q;
    last_d  = last_q;
    valid_d = 1'b0;
    if (cmd_i.load) begin
      neg_d = value_u[DATA_WIDTH-1];
      mag_d = value_u[DATA_WIDTH-1] ? (~value_u + DATA_WIDTH'(1)) : value_u;
      bcd_d = '0;
    end
    if (cmd_i.shift) begin
      bcd_d = {bcd_adj[BCD_W-2:0], mag_q[DATA_WIDTH-1]};
      mag_d = {mag_q[DATA_WIDTH-2:0], 1'b0};
    end
    if (cmd_i.locate) begin
      idx_d = lead;
    end
    if (cmd_i.emit_sign) begin
      char_d  = ASCII_MINUS;
      last_d  = 1'b0;
      valid_d = 1'b1;
    end
    if (cmd_i.emit_digit) begin
      char_d  = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, bcd_q[idx_q*4 +: 4]};
      last_d  = (idx_q == '0);
      valid_d = 1'b1;
      idx_d   = idx_q - IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    idx_q  <= idx_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign sts_o.neg      = neg_q;
  assign sts_o.idx_zero = (idx_q == '0);
  assign character_o    = char_q;
  assign last_o         = last_q;
  assign out_valid_o    = valid_q;

endmodule

`default_nettype wire

FILE: src/sbda_ctrl.sv
// controller: sequences shift, locate and character emission for one transaction
`default_nettype none

module sbda_ctrl
  import sbda_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire sbda_sts_t sts_i,
  output logic           busy,
  output sbda_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_LOCATE,
    ST_SIGN,
    ST_DIGITS
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_CONVERT;
            cnt_q   <= CNT_W'(DATA_WIDTH - 1);
          end
        end
        ST_CONVERT: begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            state_q <= ST_LOCATE;
          end
        end
        ST_LOCATE: begin
          state_q <= sts_i.neg ? ST_SIGN : ST_DIGITS;
        end
        ST_SIGN: begin
          state_q <= ST_DIGITS;
        end
        ST_DIGITS: begin
          if (sts_i.idx_zero) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy             = (state_q != ST_IDLE);
  assign cmd_o.load       = (state_q == ST_IDLE) && start;
  assign cmd_o.shift      = (state_q == ST_CONVERT);
  assign cmd_o.locate     = (state_q == ST_LOCATE);
  assign cmd_o.emit_sign  = (state_q == ST_SIGN);
  assign cmd_o.emit_digit = (state_q == ST_DIGITS);

endmodule

`default_nettype wire

FILE: src/signed_binary_to_decimal_ascii_top.sv
// top level of the signed binary to decimal ascii converter
//
// A transaction is taken when start is high while busy is low; value_i holds a
// signed two's complement integer. The block answers with its decimal text,
// one ASCII character per result, most significant first: '-' for a negative
// value, then the digits without leading zeros ('0' alone for zero). Each
// character is on character_o for one cycle with out_valid_o high; last_o marks
// the final digit. The receiver cannot stall, so results are never held.
// Sequence: double-dabble shifting at one bit per cycle over DATA_WIDTH bits
// (32), a locate state to find the leading digit, then the sign state for a
// negative value and the digit state, which emits one character per cycle (at
// most 11 characters in all); each character is registered onto character_o.
// busy drops on the cycle the last character is shown, so the next start may
// be taken on that same edge.
// Reset is asynchronous and active low; it idles the controller and clears the
// result strobe. No state is carried from one transaction to the next.
`default_nettype none

module signed_binary_to_decimal_ascii_top
  import sbda_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [DATA_WIDTH-1:0] value_i,
  output logic [CHAR_W-1:0]                 character_o,
  output logic                              last_o,
  output logic                              out_valid_o
);

  sbda_cmd_t cmd;
  sbda_sts_t sts;

  sbda_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  sbda_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .value_i     (value_i),
    .sts_o       (sts),
    .character_o (character_o),
    .last_o      (last_o),
    .out_valid_o (out_valid_o)
  );

  // every character is a minus or a decimal digit
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o == ASCII_MINUS) ||
                    ((character_o >= ASCII_ZERO) && (character_o <= ASCII_NINE)))
    else $error("character out of range");

  // the sign never ends a transaction
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (character_o == ASCII_MINUS) |-> !last_o)
    else $error("minus flagged as last");

  // controller is free exactly when the final character is out
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> !busy)
    else $error("busy after last character");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> busy)
    else $error("idle while characters remain");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !out_valid_o)
    else $error("transaction not taken");

endmodule

`default_nettype wire

FILE: tb/sv/tb_signed_binary_to_decimal_ascii_top.sv
// self-checking testbench for the signed binary to decimal ascii converter
`timescale 1ns / 100ps

module tb_signed_binary_to_decimal_ascii_top;
  import sbda_pkg::*;

  localparam int TEXT_BYTES   = 11;
  localparam int NUM_DIRECTED = 21;
  localparam int NUM_RANDOM   = 100;  // per idling phase
  localparam int NUM_PHASES   = 3;
  localparam int TAIL_CYCLES  = 60;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  // text is right-justified ascii, all zero where the predictor supplies the answer
  typedef struct packed {
    logic [DATA_WIDTH-1:0]   value;
    logic [8*TEXT_BYTES-1:0] text;
  } directed_row_t;

  logic                         clk_i  = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start  = 1'b0;
  logic signed [DATA_WIDTH-1:0] value_i = '0;
  logic                         busy;
  logic [CHAR_W-1:0]            character_o;
  logic                         last_o;
  logic                         out_valid_o;

  text_char_t pending_chars[$];
  int         errors    = 0;
  int         n_values  = 0;
  int         n_neg     = 0;
  int         n_zero    = 0;
  int         n_chars   = 0;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{32'sd0,           "0"},
    '{32'sd1,           "1"},
    '{-32'sd1,          "-1"},
    '{32'sd9,           "9"},
    '{32'sd10,          "10"},
    '{-32'sd10,         "-10"},
    '{32'h7FFF_FFFF,    "2147483647"},
    '{32'h8000_0000,    "-2147483648"},
    '{32'h8000_0001,    "-2147483647"},
    '{32'h7FFF_FFFE,    "2147483646"},
    '{32'sd99999,       '0},
    '{32'sd100000,      '0},
    '{-32'sd999999999,  '0},
    '{32'sd1000000000,  '0},
    '{-32'sd1000000000, '0},
    '{32'h5555_5555,    '0},
    '{32'hAAAA_AAAA,    '0},
    '{32'sd12345,       '0},
    '{-32'sd987654321,  '0},
    '{32'sd7,           '0},
    '{-32'sd5,          '0}
  };

  signed_binary_to_decimal_ascii_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .character_o (character_o),
    .last_o      (last_o),
    .out_valid_o (out_valid_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // queue the decimal text of one value: sign first, then digits msd first
  function automatic void push_decimal_text(input logic signed [DATA_WIDTH-1:0] v);
    logic [DATA_WIDTH-1:0] mag;
    logic [DATA_WIDTH-1:0] digit;
    logic [CHAR_W-1:0]     rev [NUM_DIGITS];
    text_char_t            c;
    int                    nd;
    mag = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
    nd = 0;
    do begin
      digit = mag % 10;
      rev[nd] = ASCII_ZERO + digit[CHAR_W-1:0];
      nd++;
      mag = mag / 10;
    end while (mag != 0);
    if (v[DATA_WIDTH-1]) begin
      c.code = ASCII_MINUS;
      c.last = 1'b0;
      pending_chars.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.code = rev[i];
      c.last = (i == 0);
      pending_chars.push_back(c);
    end
  endfunction

  // mix of full-range, small, per-digit-count and boundary values
  function automatic logic signed [DATA_WIDTH-1:0] random_value();
    logic signed [DATA_WIDTH-1:0] v;
    longint                       lo;
    longint                       hi;
    int                           sel;
    int                           k;
    sel = $urandom_range(4);
    case (sel)
      0: v = $urandom;
      1: v = $urandom_range(20);
      2: begin
        k  = $urandom_range(9);
        lo = 1;
        repeat (k) lo = lo * 10;
        hi = (k == 9) ? 64'd2147483647 : lo * 10 - 1;
        v  = $urandom_range(32'(hi), 32'(lo));
      end
      3: begin
        lo = 1;
        repeat ($urandom_range(9)) lo = lo * 10;
        v = DATA_WIDTH'(lo + $urandom_range(2) - 1);
      end
      default: v = 32'h7FFF_FFFF - $urandom_range(3);
    endcase
    // ~v reaches the most negative value from the top of the range
    if (sel != 0 && $urandom_range(1) == 1) begin
      v = $urandom_range(1) ? -v : ~v;
    end
    return v;
  endfunction

  // one transaction; text of zero means the predictor works out the characters
  task automatic send_value(input logic signed [DATA_WIDTH-1:0] v,
                            input logic [8*TEXT_BYTES-1:0]       text,
                            input int                            idle_pct);
    text_char_t c;
    int         gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(7) == 0) ? $urandom_range(60, 1) : $urandom_range(4, 1);
      start <= 1'b0;
      // let the block go idle so the gap really leaves it waiting
      @(posedge clk_i);
      while (busy) @(posedge clk_i);
      repeat (gap) begin
        value_i <= $urandom;
        @(posedge clk_i);
      end
    end
    start   <= 1'b1;
    value_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    n_values++;
    if (v[DATA_WIDTH-1]) n_neg++;
    if (v == 0) n_zero++;
    if (text != '0) begin
      for (int b = TEXT_BYTES - 1; b >= 0; b--) begin
        if (text[8*b +: 8] != 8'd0) begin
          c.code = text[8*b +: CHAR_W];
          c.last = (b == 0);
          pending_chars.push_back(c);
        end
      end
    end else begin
      push_decimal_text(v);
    end
  endtask

  task automatic wait_for_quiet();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  // result checker, compares against the oldest pending character
  always @(posedge clk_i) begin
    text_char_t exp_c;
    if (rst_ni && out_valid_o) begin
      n_chars++;
      if (pending_chars.size() == 0) begin
        $error("unexpected character: got %0d last %0b", character_o, last_o);
        errors++;
      end else begin
        exp_c = pending_chars.pop_front();
        if (character_o !== exp_c.code) begin
          $error("character: expected %0d, got %0d", exp_c.code, character_o);
          errors++;
        end
        if (last_o !== exp_c.last) begin
          $error("last: expected %0b, got %0b", exp_c.last, last_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int idle_pct [NUM_PHASES];
    idle_pct = '{0, 53, 27};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_value(directed_rows[i].value, directed_rows[i].text, 0);
    end
    wait_for_quiet();

    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int n = 0; n < NUM_RANDOM; n++) begin
        send_value(random_value(), '0, idle_pct[p]);
      end
      wait_for_quiet();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("converted %0d values (%0d negative, %0d zero), %0d characters checked",
             n_values, n_neg, n_zero, n_chars);
    $display("idling phases: back to back, sender idle 53%% and 27%%, drained between phases");
    if (errors == 0) begin
      $display("tb_signed_binary_to_decimal_ascii_top: clean");
    end else begin
      $display("tb_signed_binary_to_decimal_ascii_top: errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_signed_binary_to_decimal_ascii_top: errors");
    $finish;
  end

endmodule
